/* rtl/mawrf_pkg.sv */
package mawrf_pkg;

  localparam int DATA_W         = 32;
  localparam int CFG_W          = 6;
  localparam int DEFAULT_WINDOW = 20;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL_ALL,
    S_READ,
    S_UPDATE,
    S_PREFIX,
    S_FILL_DIV_GO,
    S_FILL_DIV_WAIT,
    S_FILL,
    S_TOTAL_GO,
    S_TOTAL_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic idle;
    logic latch_in;
    logic fill_all_step;
    logic update;
    logic prefix;
    logic div_start;
    logic div_total;
    logic fill_begin;
    logic fill_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic awaiting;
    logic first_pass;
    logic sweep_last;
    logic prefix_full;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage

/* rtl/moving_average_with_rampup_fill.sv */
// Boxcar moving average of signed Q15.16 samples over a ring of N entries, with a start-up
// fill: the first sample fills the whole window, and until one pass over the ring is done each
// later sample is stored and the entries above it take the truncated mean of the samples stored
// so far. Every accepted sample returns one average, the mean of the N entries truncated toward
// zero. N is window_size (0 means 20, values above WINDOW_MAX clamp to it); any write of
// window_size restarts the filter and is taken only while the block is idle. One sample is in
// work at a time; the bit-serial divider sets the pace. The first sample after a restart writes
// all N entries in turn before its divide, and a ramp-up sample that needs a fill runs the
// divider twice, once for the fill value and once for the average. The result sits in an
// output register so the next sample may be taken while it waits.
module moving_average_with_rampup_fill #(
  parameter int WINDOW_MAX = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [mawrf_pkg::CFG_W-1:0]  window_size,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mawrf_pkg::DATA_W-1:0] sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mawrf_pkg::DATA_W-1:0] average
);

  mawrf_pkg::cmd_t    cmd;
  mawrf_pkg::status_t status;

  assign in_stall  = !cmd.idle;
  assign cfg_ready = cmd.idle;

  mawrf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd)
  );

  mawrf_dp #(
    .WINDOW_MAX(WINDOW_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (window_size),
    .sample    (sample),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .average   (average)
  );

endmodule

/* rtl/mawrf_div.sv */
module mawrf_div #(
  parameter int SW = 37,
  parameter int CW = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [SW-1:0]                dividend,
  input  logic        [CW-1:0]                divisor,
  output logic                                done,
  output logic signed [mawrf_pkg::DATA_W-1:0] quotient
);

  localparam int IW = $clog2(SW + 1);

  logic          busy;
  logic [IW-1:0] iter;
  logic [SW-1:0] quo;
  logic [CW-1:0] rem;
  logic [CW-1:0] dvs;
  logic          neg;
  logic [CW:0]   trial;
  logic          fits;
  logic [CW-1:0] rem_next;
  logic [SW-1:0] dividend_abs;
  logic [SW-1:0] quo_neg;

  // restoring divide on magnitudes, one quotient bit per cycle
  assign trial        = {rem, quo[SW-1]};
  assign fits         = trial >= {1'b0, dvs};
  assign rem_next     = fits ? CW'(trial - {1'b0, dvs}) : trial[CW-1:0];
  assign dividend_abs = dividend[SW-1] ? (~dividend + SW'(1)) : dividend;
  assign quo_neg      = ~quo + SW'(1);
  assign quotient     = neg ? quo_neg[mawrf_pkg::DATA_W-1:0] : quo[mawrf_pkg::DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= IW'(SW);
      end else if (busy) begin
        iter <= iter - IW'(1);
        if (iter == IW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend_abs;
      rem <= '0;
      dvs <= divisor;
      neg <= dividend[SW-1];
    end else if (busy) begin
      quo <= {quo[SW-2:0], fits};
      rem <= rem_next;
    end
  end

endmodule

/* rtl/mawrf_ctrl.sv */
module mawrf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  mawrf_pkg::status_t status,
  output mawrf_pkg::cmd_t    cmd
);

  mawrf_pkg::state_t state;
  mawrf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mawrf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      mawrf_pkg::S_IDLE: begin
        cmd.idle = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          if (status.awaiting) begin
            state_next = mawrf_pkg::S_FILL_ALL;
          end else if (status.first_pass) begin
            state_next = mawrf_pkg::S_PREFIX;
          end else begin
            state_next = mawrf_pkg::S_READ;
          end
        end
      end
      mawrf_pkg::S_FILL_ALL: begin
        cmd.fill_all_step = 1'b1;
        if (status.sweep_last) begin
          state_next = mawrf_pkg::S_TOTAL_GO;
        end
      end
      // registered read of the entry being replaced
      mawrf_pkg::S_READ: begin
        state_next = mawrf_pkg::S_UPDATE;
      end
      mawrf_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = mawrf_pkg::S_TOTAL_GO;
      end
      mawrf_pkg::S_PREFIX: begin
        cmd.prefix = 1'b1;
        state_next = status.prefix_full ? mawrf_pkg::S_TOTAL_GO : mawrf_pkg::S_FILL_DIV_GO;
      end
      mawrf_pkg::S_FILL_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = mawrf_pkg::S_FILL_DIV_WAIT;
      end
      mawrf_pkg::S_FILL_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.fill_begin = 1'b1;
          state_next     = mawrf_pkg::S_FILL;
        end
      end
      mawrf_pkg::S_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.sweep_last) begin
          state_next = mawrf_pkg::S_TOTAL_GO;
        end
      end
      mawrf_pkg::S_TOTAL_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_total = 1'b1;
        state_next    = mawrf_pkg::S_TOTAL_WAIT;
      end
      mawrf_pkg::S_TOTAL_WAIT: begin
        if (status.div_done) begin
          state_next = mawrf_pkg::S_DONE;
        end
      end
      mawrf_pkg::S_DONE: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = mawrf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mawrf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/mawrf_dp.sv */
module mawrf_dp #(
  parameter int WINDOW_MAX = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic        [mawrf_pkg::CFG_W-1:0]  cfg_data,
  input  logic signed [mawrf_pkg::DATA_W-1:0] sample,
  input  mawrf_pkg::cmd_t                     cmd,
  output mawrf_pkg::status_t                  status,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [mawrf_pkg::DATA_W-1:0] average
);

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SW = mawrf_pkg::DATA_W + $clog2(WINDOW_MAX);

  function automatic logic [CW-1:0] eff_size(input logic [mawrf_pkg::CFG_W-1:0] r);
    int n;
    n = (r == '0) ? mawrf_pkg::DEFAULT_WINDOW : int'(r);
    if (n > WINDOW_MAX) n = WINDOW_MAX;
    return CW'(n);
  endfunction

  logic        [CW-1:0]                n;
  logic        [CW-1:0]                pos;
  logic        [CW-1:0]                cnt;
  logic        [CW-1:0]                pos_inc;
  logic                                awaiting;
  logic                                first_pass;
  logic signed [mawrf_pkg::DATA_W-1:0] samp;
  logic signed [mawrf_pkg::DATA_W-1:0] fill;
  logic signed [mawrf_pkg::DATA_W-1:0] rdata;
  logic signed [SW-1:0]                psum;
  logic signed [SW-1:0]                sum;
  logic signed [SW-1:0]                samp_w;
  logic signed [SW-1:0]                fill_w;
  logic signed [SW-1:0]                rdata_w;
  logic signed [SW-1:0]                psum_new;

  logic signed [mawrf_pkg::DATA_W-1:0] mem [WINDOW_MAX];
  logic                                mem_we;
  logic        [AW-1:0]                mem_waddr;
  logic signed [mawrf_pkg::DATA_W-1:0] mem_wdata;

  logic                                div_done;
  logic signed [mawrf_pkg::DATA_W-1:0] quotient;
  logic signed [SW-1:0]                div_dividend;
  logic        [CW-1:0]                div_divisor;

  assign samp_w   = SW'(samp);
  assign fill_w   = SW'(fill);
  assign rdata_w  = SW'(rdata);
  assign pos_inc  = pos + CW'(1);
  assign psum_new = psum + samp_w;

  assign status.awaiting    = awaiting;
  assign status.first_pass  = first_pass;
  assign status.sweep_last  = cnt == (n - CW'(1));
  assign status.prefix_full = pos_inc == n;
  assign status.div_done    = div_done;
  assign status.out_busy    = out_valid && out_stall;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt[AW-1:0];
    mem_wdata = samp;
    if (cmd.fill_all_step) begin
      mem_we = 1'b1;
    end
    if (cmd.update || cmd.prefix) begin
      mem_we    = 1'b1;
      mem_waddr = pos[AW-1:0];
    end
    if (cmd.fill_step) begin
      mem_we    = 1'b1;
      mem_wdata = fill;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[pos[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n          <= eff_size(mawrf_pkg::CFG_W'(mawrf_pkg::DEFAULT_WINDOW));
      pos        <= '0;
      awaiting   <= 1'b1;
      first_pass <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        n          <= eff_size(cfg_data);
        pos        <= '0;
        awaiting   <= 1'b1;
        first_pass <= 1'b1;
      end
      if (cmd.fill_all_step && status.sweep_last) begin
        awaiting <= 1'b0;
      end
      // position steps once per sample, wrapping at the window end
      if ((cmd.fill_all_step && status.sweep_last) || cmd.prefix || cmd.update) begin
        if (status.prefix_full) begin
          pos <= '0;
          if (!cmd.update) first_pass <= 1'b0;
        end else begin
          pos <= pos_inc;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      samp <= sample;
      cnt  <= '0;
    end
    if (cmd.fill_all_step) begin
      sum  <= (cnt == '0) ? samp_w : sum + samp_w;
      psum <= samp_w;
      cnt  <= cnt + CW'(1);
    end
    if (cmd.update) begin
      sum <= sum - rdata_w + samp_w;
    end
    if (cmd.prefix) begin
      psum <= psum_new;
      cnt  <= pos_inc;
      if (status.prefix_full) sum <= psum_new;
    end
    if (cmd.fill_begin) begin
      sum  <= psum;
      fill <= quotient;
    end
    if (cmd.fill_step) begin
      sum <= sum + fill_w;
      cnt <= cnt + CW'(1);
    end
    if (cmd.load_out) begin
      average <= quotient;
    end
  end

  assign div_dividend = cmd.div_total ? sum : psum;
  assign div_divisor  = cmd.div_total ? n : pos;

  mawrf_div #(
    .SW(SW),
    .CW(CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

/* verif/moving_average_with_rampup_fill_test.sv */
module moving_average_with_rampup_fill_test;

  localparam int RING_MAX     = 32;
  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_PAUSE  = 8;
  localparam int TAIL_WAIT    = 150;
  localparam int HOLD_LENGTH  = 300;
  localparam int RANDOM_ITEMS = 470;
  localparam int LIMIT_CYCLES = 400000;
  localparam int EXPECT_DEPTH = 1024;

  typedef enum int {
    KIND_ANY,
    KIND_TOP,
    KIND_BOTTOM,
    KIND_SMALL,
    KIND_COUNT
  } sample_kind_t;

  logic                                clk;
  logic                                rst;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic        [mawrf_pkg::CFG_W-1:0]  window_size;
  logic                                in_valid;
  logic                                in_stall;
  logic signed [mawrf_pkg::DATA_W-1:0] sample;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [mawrf_pkg::DATA_W-1:0] average;

  // shadow copy of the filter
  logic signed [mawrf_pkg::DATA_W-1:0] ring [RING_MAX];
  int unsigned                         ring_pos;
  bit                                  awaiting_seed;
  bit                                  ramping;
  int unsigned                         span;

  // expected averages in beat order
  logic signed [mawrf_pkg::DATA_W-1:0] expected_store [EXPECT_DEPTH];
  logic        [9:0]                   expect_wr = '0;
  logic        [9:0]                   expect_rd = '0;
  logic signed [mawrf_pkg::DATA_W-1:0] expected_average;
  int                                  failures;
  int                                  items_sent;
  bit                                  quiet;
  bit                                  hold_request;
  int                                  hold_cycles;

  moving_average_with_rampup_fill #(
    .WINDOW_MAX (RING_MAX)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .window_size (window_size),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .average     (average)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  function automatic int unsigned span_of(logic [mawrf_pkg::CFG_W-1:0] reg_value);
    int unsigned n;
    n = 32'(reg_value);
    if (n == 0) n = mawrf_pkg::DEFAULT_WINDOW;
    if (n > RING_MAX) n = RING_MAX;
    return n;
  endfunction

  function automatic void restart_filter(logic [mawrf_pkg::CFG_W-1:0] reg_value);
    for (int i = 0; i < RING_MAX; i++) ring[i] = '0;
    ring_pos      = 0;
    awaiting_seed = 1'b1;
    ramping       = 1'b1;
    span          = span_of(reg_value);
  endfunction

  // truncated mean of ring entries 0 .. count-1
  function automatic logic signed [mawrf_pkg::DATA_W-1:0] ring_mean(int unsigned count);
    longint             acc;
    logic signed [63:0] quotient;
    acc = 0;
    for (int unsigned i = 0; i < count; i++) acc += longint'(ring[i]);
    quotient = acc / longint'(count);
    return quotient[mawrf_pkg::DATA_W-1:0];
  endfunction

  function automatic logic signed [mawrf_pkg::DATA_W-1:0] predict_average(
    logic signed [mawrf_pkg::DATA_W-1:0] s
  );
    int unsigned                         pos;
    logic signed [mawrf_pkg::DATA_W-1:0] fill;
    pos = ring_pos;
    if (pos >= span) pos = 0;
    if (!ramping) begin
      ring[pos] = s;
      pos++;
      if (pos >= span) pos = 0;
    end else if (awaiting_seed) begin
      // first sample seeds the whole window
      for (int unsigned i = 0; i < span; i++) ring[i] = s;
      awaiting_seed = 1'b0;
      pos++;
      if (pos >= span) begin
        pos     = 0;
        ramping = 1'b0;
      end
    end else begin
      ring[pos] = s;
      pos++;
      fill = ring_mean(pos);
      for (int unsigned i = pos; i < span; i++) ring[i] = fill;
      if (pos >= span) begin
        pos     = 0;
        ramping = 1'b0;
      end
    end
    ring_pos = pos;
    return ring_mean(span);
  endfunction

  function automatic logic signed [mawrf_pkg::DATA_W-1:0] random_sample();
    sample_kind_t                kind;
    logic [mawrf_pkg::DATA_W-1:0] v;
    kind = sample_kind_t'($urandom_range(0, KIND_COUNT - 1));
    if ($urandom_range(0, 1)) kind = KIND_ANY;
    case (kind)
      KIND_TOP:    v = 32'h7FFF_FFFF - $urandom_range(0, 3);
      KIND_BOTTOM: v = 32'h8000_0000 + $urandom_range(0, 3);
      KIND_SMALL:  v = $urandom_range(0, 2000) - 1000;
      default:     v = $urandom;
    endcase
    return v;
  endfunction

  // entered and left at a falling edge; valid stays up for a following beat
  task automatic send_sample(input logic signed [mawrf_pkg::DATA_W-1:0] value);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    do @(posedge clk); while (in_stall);
    expected_store[expect_wr] = predict_average(value);
    expect_wr = expect_wr + 10'd1;
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expect_wr != expect_rd) @(negedge clk);
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  task automatic set_window(input logic [mawrf_pkg::CFG_W-1:0] value);
    drain();
    cfg_valid   <= 1'b1;
    window_size <= value;
    do @(posedge clk); while (!cfg_ready);
    restart_filter(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_default_window();
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh0000_0000);
    send_sample(32'shFFFF_FFFF);
    send_sample(32'sh0000_0001);
  endtask

  task automatic test_window_one();
    set_window(6'd1);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'shFFFF_FFFF);
    send_sample(32'sh0001_0000);
  endtask

  task automatic test_window_saturate();
    set_window(6'h3F);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh1234_5678);
  endtask

  task automatic test_window_zero();
    set_window(6'd0);
    send_sample(32'shFFFF_0000);
    send_sample(32'sh0003_8000);
    send_sample(32'sh8000_0001);
  endtask

  task automatic test_window_two();
    set_window(6'd2);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
  endtask

  task automatic test_window_full();
    set_window(6'd32);
    send_sample(32'shFFFF_FFFF);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh0000_0000);
  endtask

  // restart often so that ramp-up is hit many times, mostly running past the first pass
  task automatic test_random_phases(input int target);
    logic [mawrf_pkg::CFG_W-1:0] reg_value;
    int unsigned                 n;
    int unsigned                 count;
    while (items_sent < target) begin
      case ($urandom_range(0, 5))
        0:       reg_value = 6'd1;
        1:       reg_value = 6'd32;
        2:       reg_value = 6'd0;
        3:       reg_value = mawrf_pkg::CFG_W'($urandom_range(33, 63));
        default: reg_value = mawrf_pkg::CFG_W'($urandom_range(1, 31));
      endcase
      set_window(reg_value);
      n = span_of(reg_value);
      if ($urandom_range(0, 3) == 0) count = $urandom_range(1, n);
      else count = n + $urandom_range(0, 2 * n);
      repeat (count) send_sample(random_sample());
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_cycles  = HOLD_LENGTH;
    hold_request = 1'b1;
    repeat (12) send_sample(random_sample());
    while (hold_request) @(negedge clk);
    drain();
  endtask

  task automatic test_quiet_tail();
    quiet = 1'b1;
    set_window(mawrf_pkg::CFG_W'($urandom_range(1, 32)));
    repeat (40) send_sample(random_sample());
    drain();
  endtask

  // receiver side
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(negedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expect_wr == expect_rd) begin
        $error("average: no beat expected, actual %0d", average);
        failures++;
      end else begin
        expected_average = expected_store[expect_rd];
        expect_rd = expect_rd + 10'd1;
        if (average !== expected_average) begin
          $error("average: expected %0d, actual %0d", expected_average, average);
          failures++;
        end
      end
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    window_size  = '0;
    in_valid     = 1'b0;
    sample       = '0;
    failures     = 0;
    items_sent   = 0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    hold_cycles  = 0;
    restart_filter(mawrf_pkg::CFG_W'(mawrf_pkg::DEFAULT_WINDOW));
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_window();
    test_window_one();
    test_window_saturate();
    test_window_zero();
    test_window_two();
    test_window_full();
    test_random_phases(items_sent + RANDOM_ITEMS);
    test_backpressure();
    test_quiet_tail();

    drain();
    repeat (TAIL_WAIT) @(negedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(2 * CLK_HALF * LIMIT_CYCLES);
    $display("Verification failed");
    $finish;
  end

endmodule
